// File: src/tce_pkg.sv
// Shared types and opcode constants for the execute unit.
package tce_pkg;

    localparam int WORD_W = 16;

    // Register-format opcodes
    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_SUB     = 6'd1;
    localparam logic [5:0] OP_MUL     = 6'd2;
    localparam logic [5:0] OP_DIV     = 6'd3;
    localparam logic [5:0] OP_EQ      = 6'd4;
    localparam logic [5:0] OP_NEQ     = 6'd5;
    localparam logic [5:0] OP_LT      = 6'd6;
    localparam logic [5:0] OP_GT      = 6'd7;
    localparam logic [5:0] OP_LE      = 6'd8;
    localparam logic [5:0] OP_GE      = 6'd9;
    localparam logic [5:0] OP_AND     = 6'd10;
    localparam logic [5:0] OP_OR      = 6'd11;
    localparam logic [5:0] OP_XOR     = 6'd12;
    localparam logic [5:0] OP_SHL     = 6'd13;
    localparam logic [5:0] OP_SHR     = 6'd14;
    localparam logic [5:0] OP_LOAD    = 6'd15;
    localparam logic [5:0] OP_STORE   = 6'd16;
    localparam logic [5:0] OP_SYSCALL = 6'd63;

    // Immediate-format opcodes
    localparam logic [5:0] OPI_JMP  = 6'd0;
    localparam logic [5:0] OPI_JCND = 6'd1;
    localparam logic [5:0] OPI_MOVI = 6'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_SYSCALL = 2'd3;

    typedef struct packed {
        logic        instruction_format;
        logic [5:0]  operation;
        logic [3:0]  src_a;
        logic [3:0]  src_b;
        logic [3:0]  dest_reg;
        logic [15:0] immediate;
        logic [15:0] current_pc;
    } t_in_item;

    typedef struct packed {
        logic        reg_written;
        logic [15:0] written_value;
        logic        jump_taken;
        logic [15:0] jump_target;
        logic [1:0]  status;
    } t_out_item;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch instruction and read operands
        logic div_start; // load divider
        logic div_step;  // one restoring divide step
        logic mem_read;  // issue memory read
        logic finish;    // form result and commit side effects
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic is_div;
        logic is_load;
    } t_sts;

endpackage

// File: src/toy_cpu_execute_unit.sv
// Top level of the execute unit: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// One instruction at a time: after accept the controller passes through decode
// and finish states to the result; load adds a memory read state and divide
// with nonzero divisor adds the divide states (16-step restoring divider).
// Reset clears control and the register file; data memory is not cleared.
// The result holds while out is stalled and no new transaction is accepted
// until it is taken.
module toy_cpu_execute_unit #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tce_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tce_pkg::t_out_item o_out_item
);

    tce_pkg::t_cmd cmd;
    tce_pkg::t_sts sts;

    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tce_dp #(
        .NUM_REGS  (NUM_REGS),
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_item  (o_out_item)
    );

endmodule

// File: src/tce_ctrl.sv
// Controller state machine for the execute unit.
module tce_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tce_pkg::t_sts i_sts,
    output tce_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MEM   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt = 4'd0;
                    n_state = S_DIV;
                end else if (i_sts.is_load) begin
                    o_cmd.mem_read = 1'b1;
                    n_state = S_MEM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = S_FIN;
            end
            S_MEM: n_state = S_FIN;
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: src/tce_dp.sv
// Datapath: register file, data memory, ALU, serial divider, result register.
module tce_dp #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_WORDS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tce_pkg::t_in_item  i_item,
    input  tce_pkg::t_cmd      i_cmd,
    output tce_pkg::t_sts      o_sts,
    output tce_pkg::t_out_item o_item
);

    localparam int RI_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [15:0] r_rf [NUM_REGS];
    logic [15:0] r_mem [MEM_WORDS];

    tce_pkg::t_in_item r_ins;
    logic [15:0] r_a, r_b, r_d;
    logic [15:0] r_mrd;
    logic [15:0] r_quo, r_rem;
    tce_pkg::t_out_item r_out;

    // Register reads; out-of-range indices read zero
    function automatic logic [15:0] rd_reg(input logic [3:0] idx,
                                           input logic [15:0] val);
        rd_reg = ({28'd0, idx} < NUM_REGS) ? val : 16'd0;
    endfunction

    // Register indices sized to the register file depth
    logic [RI_W-1:0] a_idx, b_idx, d_idx, w_idx;
    assign a_idx = RI_W'(i_item.src_a);
    assign b_idx = RI_W'(i_item.src_b);
    assign d_idx = RI_W'(i_item.dest_reg);
    assign w_idx = RI_W'(r_ins.dest_reg);

    logic [15:0] a_raw, b_raw, d_raw;
    assign a_raw = r_rf[a_idx];
    assign b_raw = r_rf[b_idx];
    assign d_raw = r_rf[d_idx];

    // Capture transaction and operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ins <= i_item;
            r_a   <= rd_reg(i_item.src_a, a_raw);
            r_b   <= rd_reg(i_item.src_b, b_raw);
            r_d   <= rd_reg(i_item.dest_reg, d_raw);
        end
    end

    logic fmt_r;
    assign fmt_r = (r_ins.instruction_format == 1'b0);
    assign o_sts.is_div  = fmt_r && (r_ins.operation == tce_pkg::OP_DIV) && (r_b != 16'd0);
    assign o_sts.is_load = fmt_r && (r_ins.operation == tce_pkg::OP_LOAD);

    logic a_in_mem;
    assign a_in_mem = ({16'd0, r_a} < MEM_WORDS);

    // Data memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) r_mrd <= r_mem[r_a[MA_W-1:0]];
        if (i_cmd.finish && fmt_r && r_ins.operation == tce_pkg::OP_STORE && a_in_mem)
            r_mem[r_a[MA_W-1:0]] <= r_b;
    end

    // Restoring divider, one quotient bit per cycle
    logic [16:0] div_trial;
    assign div_trial = {r_rem, r_quo[15]} - {1'b0, r_b};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= r_a;
            r_rem <= 16'd0;
        end else if (i_cmd.div_step) begin
            if (!div_trial[16]) begin
                r_rem <= div_trial[15:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= {r_rem[14:0], r_quo[15]};
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    // Result formation
    logic [15:0] res;
    logic        wr, jmp;
    logic [1:0]  st;
    logic [31:0] prod;
    assign prod = r_a * r_b;

    always_comb begin
        res = 16'd0;
        wr  = 1'b0;
        jmp = 1'b0;
        st  = tce_pkg::ST_OK;
        if (fmt_r) begin
            unique case (r_ins.operation)
                tce_pkg::OP_ADD: begin res = r_a + r_b; wr = 1'b1; end
                tce_pkg::OP_SUB: begin res = r_a - r_b; wr = 1'b1; end
                tce_pkg::OP_MUL: begin res = prod[15:0]; wr = 1'b1; end
                tce_pkg::OP_DIV: begin
                    wr = 1'b1;
                    if (r_b == 16'd0) begin
                        res = 16'hFFFF;
                        st  = tce_pkg::ST_DIVZERO;
                    end else begin
                        res = r_quo;
                    end
                end
                tce_pkg::OP_EQ:  begin res = {15'd0, r_a == r_b}; wr = 1'b1; end
                tce_pkg::OP_NEQ: begin res = {15'd0, r_a != r_b}; wr = 1'b1; end
                tce_pkg::OP_LT:  begin res = {15'd0, r_a <  r_b}; wr = 1'b1; end
                tce_pkg::OP_GT:  begin res = {15'd0, r_a >  r_b}; wr = 1'b1; end
                tce_pkg::OP_LE:  begin res = {15'd0, r_a <= r_b}; wr = 1'b1; end
                tce_pkg::OP_GE:  begin res = {15'd0, r_a >= r_b}; wr = 1'b1; end
                tce_pkg::OP_AND: begin res = r_a & r_b; wr = 1'b1; end
                tce_pkg::OP_OR:  begin res = r_a | r_b; wr = 1'b1; end
                tce_pkg::OP_XOR: begin res = r_a ^ r_b; wr = 1'b1; end
                tce_pkg::OP_SHL: begin
                    res = (r_b[15:4] != 12'd0) ? 16'd0 : (r_a << r_b[3:0]);
                    wr = 1'b1;
                end
                tce_pkg::OP_SHR: begin
                    res = (r_b[15:4] != 12'd0) ? 16'd0 : (r_a >> r_b[3:0]);
                    wr = 1'b1;
                end
                tce_pkg::OP_LOAD: begin
                    res = a_in_mem ? r_mrd : 16'd0;
                    wr = 1'b1;
                end
                tce_pkg::OP_STORE:   ;
                tce_pkg::OP_SYSCALL: st = tce_pkg::ST_SYSCALL;
                default:             st = tce_pkg::ST_ILLEGAL;
            endcase
        end else begin
            unique case (r_ins.operation)
                tce_pkg::OPI_JMP:  jmp = 1'b1;
                tce_pkg::OPI_JCND: jmp = (r_ins.immediate <= r_ins.current_pc) &&
                                         (r_d != 16'd0);
                tce_pkg::OPI_MOVI: begin res = r_ins.immediate; wr = 1'b1; end
                default:           st = tce_pkg::ST_ILLEGAL;
            endcase
        end
    end

    logic wr_ok;
    assign wr_ok = wr && ({28'd0, r_ins.dest_reg} < NUM_REGS);

    // Register file reset and write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_rf[i] <= 16'd0;
        end else if (i_cmd.finish && wr_ok) begin
            r_rf[w_idx] <= res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.reg_written   <= wr_ok;
            r_out.written_value <= wr_ok ? res : 16'd0;
            r_out.jump_taken    <= jmp;
            r_out.jump_target   <= jmp ? r_ins.immediate : 16'd0;
            r_out.status        <= st;
        end
    end

    assign o_item = r_out;

endmodule
